// File: hw/rtl/bearing_to_waypoint_core_macros.svh
// ---------------------------------------------------------------------------
// bearing to waypoint assertion macros
// shared property shapes for the checker
// ---------------------------------------------------------------------------
`ifndef BEARING_TO_WAYPOINT_CORE_MACROS_SVH
`define BEARING_TO_WAYPOINT_CORE_MACROS_SVH

// same-cycle implication
`define BTW_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BTW_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/btw_pkg.sv
// ---------------------------------------------------------------------------
// btw_pkg
// constants, widths and the arctangent table for the bearing core
// ---------------------------------------------------------------------------
package btw_pkg;

    localparam int FRAC_BITS     = 23;
    localparam int ANG_FRAC      = 30;
    localparam int SCALE_SH      = ANG_FRAC - FRAC_BITS;
    localparam int CORDIC_STAGES = 24;
    localparam int TAB_LEN       = 32;
    localparam int N_ITER        = (CORDIC_STAGES > TAB_LEN) ? TAB_LEN : CORDIC_STAGES;

    localparam int ZW = 41;
    localparam int RW = 32;
    localparam int PW = 64;
    localparam int NW = 43;
    localparam int VW = 45;
    localparam int NORM_SH = 40;

    localparam logic signed [ZW-1:0] DEG90  = ZW'(64'd90 << ANG_FRAC);
    localparam logic signed [ZW-1:0] DEG180 = ZW'(64'd180 << ANG_FRAC);
    localparam logic signed [ZW-1:0] DEG360 = ZW'(64'd360 << ANG_FRAC);
    localparam logic signed [RW-1:0] KGAIN  = RW'(64'd652032874);
    localparam logic [NW-1:0]        NORM_HI = NW'(64'd1 << (NORM_SH + 1));
    localparam int                   HEAD_LIM = 180 << FRAC_BITS;
    localparam int                   ROUND_HALF = 1 << (SCALE_SH - 1);
    localparam logic [63:0]          RAD2DEG_Q26 = 64'd3845054675;

    typedef logic signed [ZW-1:0] atan_tab_t [TAB_LEN];

    function automatic logic [63:0] long_div(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        int          b;
        q = '0;
        r = '0;
        for (b = 63; b >= 0; b--) begin
            r = {r[63:0], num[b]};
            if (r >= {1'b0, den}) begin
                r = r - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic atan_tab_t build_atan_tab();
        atan_tab_t   tab;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] r;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] term;
        logic [63:0] prod;
        int          e;
        int          i;
        int          k;
        tab[0] = ZW'(64'd45 << ANG_FRAC);
        for (i = 1; i < TAB_LEN; i++) begin
            pos = '0;
            neg = '0;
            for (k = 0; k < 31; k++) begin
                e = i * (2 * k + 1);
                if (e <= 60) begin
                    term = long_div(64'd1 << (60 - e), 64'(2 * k + 1));
                    if ((k % 2) == 0) begin
                        pos = pos + term;
                    end else begin
                        neg = neg + term;
                    end
                end
            end
            r    = pos - neg;
            a    = r >> 32;
            b    = r & 64'hFFFF_FFFF;
            prod = a * RAD2DEG_Q26 + ((b * RAD2DEG_Q26) >> 32);
            tab[i] = ZW'(prod >> 24);
        end
        return tab;
    endfunction

    localparam atan_tab_t ATAN_TAB = build_atan_tab();

endpackage

// File: hw/rtl/bearing_to_waypoint_core.sv
// ---------------------------------------------------------------------------
// bearing_to_waypoint_core
// initial bearing from a current position to a target position
// ---------------------------------------------------------------------------
// Items enter on the s_ channel (valid/ready) as here/goal latitude and
// longitude in degrees, signed with 23 fraction bits. Results leave on the
// m_ channel: heading in degrees, clockwise from north, -180..180, same
// format, plus a coincident flag (heading forced to 0).
// cfg_wr_en/cfg_wr_data set the method bit (0 spherical forward azimuth,
// 1 flat angle from north); write it only while no item is in flight.
// The pipe has 63 register stages: input and range reduction (4),
// sine/cosine CORDIC (24), flip and products (4), operand normalisation
// (5), arctangent CORDIC (24), clamp and rounding (2); each CORDIC
// iteration is a stage. Throughput is one item per cycle unless the pipe
// is full and m_ready is low.
// Reset clears every valid bit and the method bit.
// When m_ready is low the result holds; stages behind it keep filling
// any empty slots, so s_ready stays high until the pipe is full.
// ---------------------------------------------------------------------------
module bearing_to_waypoint_core
    import btw_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [30:0] s_here_lat,
    input  logic signed [31:0] s_here_lon,
    input  logic signed [30:0] s_goal_lat,
    input  logic signed [31:0] s_goal_lon,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_heading,
    output logic               m_coincident
);

    localparam int ST_R2  = 3;
    localparam int ST_ROT = ST_R2 + 1;
    localparam int ST_F   = ST_ROT + N_ITER;
    localparam int ST_M1  = ST_F + 1;
    localparam int ST_M2  = ST_M1 + 1;
    localparam int ST_M3  = ST_M2 + 1;
    localparam int ST_V0  = ST_M3 + 1;
    localparam int ST_V4  = ST_V0 + 4;
    localparam int ST_VEC = ST_V4 + 1;
    localparam int ST_O0  = ST_VEC + N_ITER;
    localparam int ST_OUT = ST_O0 + 1;
    localparam int NST    = ST_OUT + 1;

    typedef struct packed {
        logic               meth;
        logic               coin;
        logic               west;
        logic signed [31:0] dlat;
        logic signed [32:0] dlon;
    } side_t;

    typedef struct packed {
        logic signed [RW-1:0] x;
        logic signed [RW-1:0] y;
        logic signed [ZW-1:0] z;
    } rot_t;

    typedef struct packed {
        logic                 meth;
        logic                 coin;
        logic                 west;
        logic                 spec;
        logic signed [ZW-1:0] sval;
    } tail_t;

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [ZW-1:0] z;
    } vec_t;

    // handshake and valid chain
    logic           method_reg;
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] vld_next;
    logic [NST-1:0] en;

    assign en[NST-1] = !vld_reg[NST-1] || m_ready;
    for (genvar g = 0; g < NST - 1; g++) begin : g_en
        assign en[g] = !vld_reg[g] || en[g+1];
    end

    assign vld_next = ({vld_reg[NST-2:0], s_valid} & en) | (vld_reg & ~en);
    assign s_ready  = en[0];
    assign m_valid  = vld_reg[ST_OUT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            method_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
            if (cfg_wr_en) begin
                method_reg <= cfg_wr_data;
            end
        end
    end

    // input stage
    side_t                side_p0_next;
    side_t                side_p0_reg;
    logic signed [ZW-1:0] th_p0_next [3];
    logic signed [ZW-1:0] th_p0_reg  [3];

    always_comb begin
        side_p0_next.meth = method_reg;
        side_p0_next.coin = (s_here_lat == s_goal_lat) && (s_here_lon == s_goal_lon);
        side_p0_next.west = s_goal_lon < s_here_lon;
        side_p0_next.dlat = 32'(s_goal_lat) - 32'(s_here_lat);
        side_p0_next.dlon = 33'(s_goal_lon) - 33'(s_here_lon);
        th_p0_next[0] = ZW'(s_here_lat) <<< SCALE_SH;
        th_p0_next[1] = ZW'(s_goal_lat) <<< SCALE_SH;
        th_p0_next[2] = ZW'(side_p0_next.dlon) <<< SCALE_SH;
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            side_p0_reg <= side_p0_next;
            th_p0_reg   <= th_p0_next;
        end
    end

    // range reduction
    side_t                side_r0_reg;
    side_t                side_r1_reg;
    logic signed [ZW-1:0] th_r0_next [3];
    logic signed [ZW-1:0] th_r0_reg  [3];
    logic signed [ZW-1:0] th_r1_next [3];
    logic signed [ZW-1:0] th_r1_reg  [3];

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            if (th_p0_reg[l] >= DEG360) begin
                th_r0_next[l] = th_p0_reg[l] - DEG360;
            end else if (th_p0_reg[l] <= -DEG360) begin
                th_r0_next[l] = th_p0_reg[l] + DEG360;
            end else begin
                th_r0_next[l] = th_p0_reg[l];
            end
            if (th_r0_reg[l] >= DEG180) begin
                th_r1_next[l] = th_r0_reg[l] - DEG360;
            end else if (th_r0_reg[l] < -DEG180) begin
                th_r1_next[l] = th_r0_reg[l] + DEG360;
            end else begin
                th_r1_next[l] = th_r0_reg[l];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            side_r0_reg <= side_p0_reg;
            th_r0_reg   <= th_r0_next;
        end
        if (en[2]) begin
            side_r1_reg <= side_r0_reg;
            th_r1_reg   <= th_r1_next;
        end
    end

    // quadrant fold and sine/cosine CORDIC, one iteration a stage
    rot_t       rot_reg      [N_ITER+1][3];
    logic [2:0] flip_rot_reg [N_ITER+1];
    side_t      side_rot_reg [N_ITER+1];
    rot_t       rot_r2_next  [3];
    logic [2:0] flip_r2_next;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            rot_r2_next[l].x = KGAIN;
            rot_r2_next[l].y = '0;
            flip_r2_next[l]  = 1'b0;
            if (th_r1_reg[l] > DEG90) begin
                rot_r2_next[l].z = th_r1_reg[l] - DEG180;
                flip_r2_next[l]  = 1'b1;
            end else if (th_r1_reg[l] < -DEG90) begin
                rot_r2_next[l].z = th_r1_reg[l] + DEG180;
                flip_r2_next[l]  = 1'b1;
            end else begin
                rot_r2_next[l].z = th_r1_reg[l];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[ST_R2]) begin
            rot_reg[0]      <= rot_r2_next;
            flip_rot_reg[0] <= flip_r2_next;
            side_rot_reg[0] <= side_r1_reg;
        end
    end

    for (genvar k = 0; k < N_ITER; k++) begin : g_rot
        rot_t rot_next [3];

        always_comb begin
            for (int l = 0; l < 3; l++) begin
                if (!rot_reg[k][l].z[ZW-1]) begin
                    rot_next[l].x = rot_reg[k][l].x - (rot_reg[k][l].y >>> k);
                    rot_next[l].y = rot_reg[k][l].y + (rot_reg[k][l].x >>> k);
                    rot_next[l].z = rot_reg[k][l].z - ATAN_TAB[k];
                end else begin
                    rot_next[l].x = rot_reg[k][l].x + (rot_reg[k][l].y >>> k);
                    rot_next[l].y = rot_reg[k][l].y - (rot_reg[k][l].x >>> k);
                    rot_next[l].z = rot_reg[k][l].z + ATAN_TAB[k];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en[ST_ROT+k]) begin
                rot_reg[k+1]      <= rot_next;
                flip_rot_reg[k+1] <= flip_rot_reg[k];
                side_rot_reg[k+1] <= side_rot_reg[k];
            end
        end
    end

    // sign flip, products, denominator, vector operands
    logic signed [RW-1:0] cos_f_next [3];
    logic signed [RW-1:0] sin_f_next [3];
    logic signed [RW-1:0] cos_f_reg  [3];
    logic signed [RW-1:0] sin_f_reg  [3];
    side_t                side_f_reg;
    logic signed [PW-1:0] pnum_m1_next;
    logic signed [PW-1:0] pa_m1_next;
    logic signed [PW-1:0] pb_m1_next;
    logic signed [PW-1:0] pnum_m1_reg;
    logic signed [PW-1:0] pa_m1_reg;
    logic signed [PW-1:0] pb_m1_reg;
    logic signed [RW-1:0] cd_m1_reg;
    side_t                side_m1_reg;
    logic signed [PW-1:0] q_m2_next;
    logic signed [PW-1:0] q_m2_reg;
    logic signed [PW-1:0] pnum_m2_reg;
    logic signed [PW-1:0] pa_m2_reg;
    side_t                side_m2_reg;
    logic signed [PW-1:0] vx_m3_next;
    logic signed [PW-1:0] vy_m3_next;
    logic signed [PW-1:0] vx_m3_reg;
    logic signed [PW-1:0] vy_m3_reg;
    logic signed [PW-1:0] dlon_ext;
    tail_t                tail_m3_next;
    tail_t                tail_m3_reg;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            cos_f_next[l] = flip_rot_reg[N_ITER][l] ? -rot_reg[N_ITER][l].x
                                                   : rot_reg[N_ITER][l].x;
            sin_f_next[l] = flip_rot_reg[N_ITER][l] ? -rot_reg[N_ITER][l].y
                                                   : rot_reg[N_ITER][l].y;
        end
        pnum_m1_next = cos_f_reg[1] * sin_f_reg[2];
        pa_m1_next   = cos_f_reg[0] * sin_f_reg[1];
        pb_m1_next   = sin_f_reg[0] * cos_f_reg[1];
        q_m2_next    = $signed(pb_m1_reg[ANG_FRAC+RW-1:ANG_FRAC]) * cd_m1_reg;
        dlon_ext     = PW'(side_m2_reg.dlon);
        tail_m3_next.meth = side_m2_reg.meth;
        tail_m3_next.coin = side_m2_reg.coin;
        tail_m3_next.west = side_m2_reg.west;
        tail_m3_next.spec = 1'b0;
        tail_m3_next.sval = '0;
        if (side_m2_reg.meth) begin
            vy_m3_next = (dlon_ext[PW-1] ? -dlon_ext : dlon_ext) <<< SCALE_SH;
            vx_m3_next = PW'(side_m2_reg.dlat) <<< SCALE_SH;
        end else begin
            vy_m3_next = pnum_m2_reg;
            vx_m3_next = pa_m2_reg - q_m2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[ST_F]) begin
            cos_f_reg  <= cos_f_next;
            sin_f_reg  <= sin_f_next;
            side_f_reg <= side_rot_reg[N_ITER];
        end
        if (en[ST_M1]) begin
            pnum_m1_reg <= pnum_m1_next;
            pa_m1_reg   <= pa_m1_next;
            pb_m1_reg   <= pb_m1_next;
            cd_m1_reg   <= cos_f_reg[2];
            side_m1_reg <= side_f_reg;
        end
        if (en[ST_M2]) begin
            q_m2_reg    <= q_m2_next;
            pnum_m2_reg <= pnum_m1_reg;
            pa_m2_reg   <= pa_m1_reg;
            side_m2_reg <= side_m1_reg;
        end
        if (en[ST_M3]) begin
            vx_m3_reg   <= vx_m3_next;
            vy_m3_reg   <= vy_m3_next;
            tail_m3_reg <= tail_m3_next;
        end
    end

    // special directions and normalisation
    logic [PW-1:0]        ux_v0;
    logic [PW-1:0]        uy_v0;
    logic [PW-1:0]        mx_v0_next;
    logic [PW-1:0]        mx_v0_reg;
    tail_t                tail_v0_next;
    tail_t                tail_v_reg [4];
    logic signed [PW-1:0] vx_v0_reg;
    logic signed [PW-1:0] vy_v0_reg;
    logic [5:0]           lead_v1_next;
    logic [5:0]           lead_v1_reg;
    logic signed [PW-1:0] vx_v1_reg;
    logic signed [PW-1:0] vy_v1_reg;
    logic [5:0]           sh_v2;
    logic signed [NW-1:0] x_v2_next;
    logic signed [NW-1:0] y_v2_next;
    logic signed [NW-1:0] x_v2_reg;
    logic signed [NW-1:0] y_v2_reg;
    logic [NW-1:0]        ux_v3;
    logic [NW-1:0]        uy_v3;
    logic signed [NW-1:0] x_v3_next;
    logic signed [NW-1:0] y_v3_next;
    logic signed [NW-1:0] x_v3_reg;
    logic signed [NW-1:0] y_v3_reg;
    vec_t                 vec_v4_next;

    always_comb begin
        ux_v0 = vx_m3_reg[PW-1] ? PW'(-vx_m3_reg) : PW'(vx_m3_reg);
        uy_v0 = vy_m3_reg[PW-1] ? PW'(-vy_m3_reg) : PW'(vy_m3_reg);
        mx_v0_next   = (ux_v0 > uy_v0) ? ux_v0 : uy_v0;
        tail_v0_next = tail_m3_reg;
        if (vy_m3_reg == '0) begin
            tail_v0_next.spec = 1'b1;
            tail_v0_next.sval = vx_m3_reg[PW-1] ? DEG180 : '0;
        end else if (vx_m3_reg == '0) begin
            tail_v0_next.spec = 1'b1;
            tail_v0_next.sval = vy_m3_reg[PW-1] ? -DEG90 : DEG90;
        end

        lead_v1_next = '0;
        for (int b = 0; b < PW; b++) begin
            if (mx_v0_reg[b]) begin
                lead_v1_next = 6'(b);
            end
        end

        if (lead_v1_reg >= 6'(NORM_SH)) begin
            sh_v2     = lead_v1_reg - 6'(NORM_SH);
            x_v2_next = NW'(vx_v1_reg >>> sh_v2);
            y_v2_next = NW'(vy_v1_reg >>> sh_v2);
        end else begin
            sh_v2     = 6'(NORM_SH) - lead_v1_reg;
            x_v2_next = NW'(vx_v1_reg <<< sh_v2);
            y_v2_next = NW'(vy_v1_reg <<< sh_v2);
        end

        ux_v3 = x_v2_reg[NW-1] ? NW'(-x_v2_reg) : NW'(x_v2_reg);
        uy_v3 = y_v2_reg[NW-1] ? NW'(-y_v2_reg) : NW'(y_v2_reg);
        if (ux_v3 >= NORM_HI || uy_v3 >= NORM_HI) begin
            x_v3_next = x_v2_reg >>> 1;
            y_v3_next = y_v2_reg >>> 1;
        end else begin
            x_v3_next = x_v2_reg;
            y_v3_next = y_v2_reg;
        end

        if (x_v3_reg[NW-1]) begin
            vec_v4_next.x = -VW'(x_v3_reg);
            vec_v4_next.y = -VW'(y_v3_reg);
            vec_v4_next.z = y_v3_reg[NW-1] ? -DEG180 : DEG180;
        end else begin
            vec_v4_next.x = VW'(x_v3_reg);
            vec_v4_next.y = VW'(y_v3_reg);
            vec_v4_next.z = '0;
        end
    end

    // arctangent CORDIC, one iteration a stage
    vec_t  vec_reg      [N_ITER+1];
    tail_t tail_vec_reg [N_ITER+1];

    always_ff @(posedge aclk) begin
        if (en[ST_V0]) begin
            mx_v0_reg     <= mx_v0_next;
            vx_v0_reg     <= vx_m3_reg;
            vy_v0_reg     <= vy_m3_reg;
            tail_v_reg[0] <= tail_v0_next;
        end
        if (en[ST_V0+1]) begin
            lead_v1_reg   <= lead_v1_next;
            vx_v1_reg     <= vx_v0_reg;
            vy_v1_reg     <= vy_v0_reg;
            tail_v_reg[1] <= tail_v_reg[0];
        end
        if (en[ST_V0+2]) begin
            x_v2_reg      <= x_v2_next;
            y_v2_reg      <= y_v2_next;
            tail_v_reg[2] <= tail_v_reg[1];
        end
        if (en[ST_V0+3]) begin
            x_v3_reg      <= x_v3_next;
            y_v3_reg      <= y_v3_next;
            tail_v_reg[3] <= tail_v_reg[2];
        end
        if (en[ST_V4]) begin
            vec_reg[0]      <= vec_v4_next;
            tail_vec_reg[0] <= tail_v_reg[3];
        end
    end

    for (genvar k = 0; k < N_ITER; k++) begin : g_vec
        vec_t vec_next;

        always_comb begin
            if (!vec_reg[k].y[VW-1] && (vec_reg[k].y != '0)) begin
                vec_next.x = vec_reg[k].x + (vec_reg[k].y >>> k);
                vec_next.y = vec_reg[k].y - (vec_reg[k].x >>> k);
                vec_next.z = vec_reg[k].z + ATAN_TAB[k];
            end else begin
                vec_next.x = vec_reg[k].x - (vec_reg[k].y >>> k);
                vec_next.y = vec_reg[k].y + (vec_reg[k].x >>> k);
                vec_next.z = vec_reg[k].z - ATAN_TAB[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en[ST_VEC+k]) begin
                vec_reg[k+1]      <= vec_next;
                tail_vec_reg[k+1] <= tail_vec_reg[k];
            end
        end
    end

    // clamp, method adjust, rounding
    logic signed [ZW-1:0] zc_o0;
    logic signed [ZW-1:0] zf_o0_next;
    logic signed [ZW-1:0] zf_o0_reg;
    logic                 coin_o0_reg;
    logic signed [ZW-1:0] hd_out;
    logic signed [31:0]   m_heading_next;
    logic signed [31:0]   m_heading_reg;
    logic                 m_coincident_reg;

    always_comb begin
        if (vec_reg[N_ITER].z > DEG180) begin
            zc_o0 = DEG180;
        end else if (vec_reg[N_ITER].z < -DEG180) begin
            zc_o0 = -DEG180;
        end else begin
            zc_o0 = vec_reg[N_ITER].z;
        end
        zf_o0_next = tail_vec_reg[N_ITER].spec ? tail_vec_reg[N_ITER].sval : zc_o0;
        if (tail_vec_reg[N_ITER].meth) begin
            if (zf_o0_next[ZW-1]) begin
                zf_o0_next = '0;
            end
            if (tail_vec_reg[N_ITER].west) begin
                zf_o0_next = -zf_o0_next;
            end
        end

        hd_out = (zf_o0_reg + ZW'(ROUND_HALF)) >>> SCALE_SH;
        if (hd_out > ZW'(HEAD_LIM)) begin
            hd_out = ZW'(HEAD_LIM);
        end else if (hd_out < -ZW'(HEAD_LIM)) begin
            hd_out = -ZW'(HEAD_LIM);
        end
        m_heading_next = coin_o0_reg ? '0 : 32'(hd_out);
    end

    always_ff @(posedge aclk) begin
        if (en[ST_O0]) begin
            zf_o0_reg   <= zf_o0_next;
            coin_o0_reg <= tail_vec_reg[N_ITER].coin;
        end
        if (en[ST_OUT]) begin
            m_heading_reg    <= m_heading_next;
            m_coincident_reg <= coin_o0_reg;
        end
    end

    assign m_heading    = m_heading_reg;
    assign m_coincident = m_coincident_reg;

endmodule

// File: hw/rtl/btw_checker.sv
// ---------------------------------------------------------------------------
// btw_checker
// port-level checks for the bearing core, bound to the core module
// ---------------------------------------------------------------------------
`include "bearing_to_waypoint_core_macros.svh"

module btw_checker
    import btw_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               cfg_wr_en,
    input logic               cfg_wr_data,
    input logic               s_valid,
    input logic               s_ready,
    input logic signed [30:0] s_here_lat,
    input logic signed [31:0] s_here_lon,
    input logic signed [30:0] s_goal_lat,
    input logic signed [31:0] s_goal_lon,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [31:0] m_heading,
    input logic               m_coincident
);

    // coincident item carries a zero heading
    `BTW_ASSERT_NOW(a_coin_zero, aclk, aresetn, m_valid && m_coincident, m_heading == 32'sd0, "coincident item with nonzero heading")

    // heading stays within half a turn
    `BTW_ASSERT_NOW(a_head_range, aclk, aresetn, m_valid, (m_heading <= 32'(HEAD_LIM)) && (m_heading >= -32'(HEAD_LIM)), "heading out of range")

    // empty output means the pipe can take an item
    `BTW_ASSERT_NOW(a_ready_when_empty, aclk, aresetn, !m_valid, s_ready, "input blocked with empty output")

    // stalled result holds
    `BTW_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_heading) && $stable(m_coincident), "stalled result changed")

endmodule

bind bearing_to_waypoint_core btw_checker u_btw_checker (.*);

// File: sim/bearing_to_waypoint_core_test.sv
// ---------------------------------------------------------------------------
// bearing_to_waypoint_core_test
// self-checking bench for the waypoint bearing core
// ---------------------------------------------------------------------------
// Feeds position pairs through the valid/ready input channel and compares
// each heading and coincident flag with a bit-accurate CORDIC predictor.
// Both the spherical and the flat method are run, with random idling on
// both sides, a long output stall and a full drain between phases.
// ---------------------------------------------------------------------------
module bearing_to_waypoint_core_test;
    import btw_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [30:0] here_lat;
        logic signed [31:0] here_lon;
        logic signed [30:0] goal_lat;
        logic signed [31:0] goal_lon;
    } fix_t;

    typedef struct packed {
        logic signed [31:0] heading;
        logic               coincident;
    } bearing_t;

    localparam int LAT_MAX  = 754974720;
    localparam int LON_MAX  = 1509949440;
    localparam int DRAIN    = 80;
    localparam int WATCHDOG = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam logic METHOD_SPHERE = 1'b0;
    localparam logic METHOD_FLAT   = 1'b1;

    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    logic               cfg_wr_data;
    logic               s_valid;
    logic               s_ready;
    logic signed [30:0] s_here_lat;
    logic signed [31:0] s_here_lon;
    logic signed [30:0] s_goal_lat;
    logic signed [31:0] s_goal_lon;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_heading;
    logic               m_coincident;

    bearing_to_waypoint_core dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_here_lat   (s_here_lat),
        .s_here_lon   (s_here_lon),
        .s_goal_lat   (s_goal_lat),
        .s_goal_lon   (s_goal_lon),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_heading    (m_heading),
        .m_coincident (m_coincident)
    );

    fix_t     fix_q[$];
    bearing_t bearing_q[$];
    logic     method_bit;
    int       mismatches;
    int       results_seen;
    int       flat_seen;
    int       sphere_seen;
    int       coinc_seen;
    bit       src_idle_on;
    bit       sink_idle_on;
    bit       hold_req;
    int       sink_hold;
    int       src_gap;
    int       sink_gap;
    int       quiet_cycles;
    bit       timed_out;
    bit       stim_done;
    longint   atan_lut [TAB_LEN];

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // predictor arithmetic
    function automatic longint deg_q30(input longint d);
        return d <<< ANG_FRAC;
    endfunction

    function automatic longint shr_floor(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint absval(input longint v);
        return v < 0 ? -v : v;
    endfunction

    task automatic fill_atan_lut();
        longint unsigned pos, neg, r, a, b, term;
        int e;
        atan_lut[0] = deg_q30(45);
        for (int i = 1; i < TAB_LEN; i++) begin
            pos = 0;
            neg = 0;
            for (int k = 0; i * (2 * k + 1) <= 60; k++) begin
                e = i * (2 * k + 1);
                term = (64'd1 << (60 - e)) / longint'(2 * k + 1);
                if (k % 2 == 0) pos += term;
                else neg += term;
            end
            r = pos - neg;
            a = r >> 32;
            b = r & 64'hFFFF_FFFF;
            atan_lut[i] = longint'((a * 64'd3845054675 + ((b * 64'd3845054675) >> 32)) >> 24);
        end
    endtask

    function automatic void rotate_sincos(input longint th, output longint c,
                                          output longint s);
        longint t, x, y, z, dx, dy;
        bit flip;
        t = th % deg_q30(360);
        x = 652032874;
        y = 0;
        flip = 0;
        if (t >= deg_q30(180)) t -= deg_q30(360);
        else if (t < -deg_q30(180)) t += deg_q30(360);
        if (t > deg_q30(90)) begin
            t -= deg_q30(180);
            flip = 1;
        end else if (t < -deg_q30(90)) begin
            t += deg_q30(180);
            flip = 1;
        end
        z = t;
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            dx = shr_floor(y, i);
            dy = shr_floor(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_lut[i];
            end else begin
                x += dx; y -= dy; z += atan_lut[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic longint vector_angle(input longint yi, input longint xi);
        longint x, y, z, dx, dy, m;
        x = xi;
        y = yi;
        z = 0;
        if (y == 0) return x >= 0 ? 0 : deg_q30(180);
        if (x == 0) return y > 0 ? deg_q30(90) : -deg_q30(90);
        forever begin
            m = absval(x) > absval(y) ? absval(x) : absval(y);
            if (m < (64'sd1 <<< 41)) break;
            x = shr_floor(x, 1);
            y = shr_floor(y, 1);
        end
        forever begin
            m = absval(x) > absval(y) ? absval(x) : absval(y);
            if (m >= (64'sd1 <<< 40)) break;
            x *= 2;
            y *= 2;
        end
        if (x < 0) begin
            z = y >= 0 ? deg_q30(180) : -deg_q30(180);
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            dx = shr_floor(y, i);
            dy = shr_floor(x, i);
            if (y > 0) begin
                x += dx; y -= dy; z += atan_lut[i];
            end else begin
                x -= dx; y += dy; z -= atan_lut[i];
            end
        end
        if (z > deg_q30(180)) z = deg_q30(180);
        if (z < -deg_q30(180)) z = -deg_q30(180);
        return z;
    endfunction

    function automatic bearing_t predict_bearing(input fix_t f, input logic meth);
        bearing_t res;
        longint hl, hn, gl, gn, z, hd, lim;
        longint c1, s1, c2, s2, cd, sd, dlat, dlon;
        hl = f.here_lat;
        hn = f.here_lon;
        gl = f.goal_lat;
        gn = f.goal_lon;
        if (hl == gl && hn == gn) begin
            res.heading = '0;
            res.coincident = 1'b1;
            return res;
        end
        if (meth == METHOD_SPHERE) begin
            rotate_sincos(hl <<< SCALE_SH, c1, s1);
            rotate_sincos(gl <<< SCALE_SH, c2, s2);
            rotate_sincos((gn - hn) <<< SCALE_SH, cd, sd);
            z = vector_angle(c2 * sd, c1 * s2 - shr_floor(s1 * c2, ANG_FRAC) * cd);
        end else begin
            dlat = (gl - hl) <<< SCALE_SH;
            dlon = (gn - hn) <<< SCALE_SH;
            z = vector_angle(absval(dlon), dlat);
            if (z < 0) z = 0;
            if (gn < hn) z = -z;
        end
        hd = shr_floor(z + (64'sd1 <<< (SCALE_SH - 1)), SCALE_SH);
        lim = 64'sd180 <<< FRAC_BITS;
        if (hd > lim) hd = lim;
        if (hd < -lim) hd = -lim;
        res.heading = hd[31:0];
        res.coincident = 1'b0;
        return res;
    endfunction

    // stimulus
    function automatic fix_t random_fix();
        fix_t f;
        int sel;
        sel = $urandom_range(0, 9);
        f.here_lat = 31'($signed($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX);
        f.here_lon = int'($urandom_range(0, 32'hB3FF_FFFF)) - LON_MAX;
        if (sel == 0) begin
            f.goal_lat = f.here_lat;
            f.goal_lon = f.here_lon;
        end else if (sel < 4) begin
            // short hops, typical waypoint spacing
            f.goal_lat = 31'(f.here_lat + ($signed($urandom_range(0, 200000)) - 100000));
            f.goal_lon = f.here_lon + ($signed($urandom_range(0, 200000)) - 100000);
        end else if (sel == 4) begin
            f.goal_lat = f.here_lat;
            f.goal_lon = f.here_lon + ($signed($urandom_range(0, 2000)) - 1000);
        end else if (sel == 5) begin
            f.goal_lat = 31'(f.here_lat + ($signed($urandom_range(0, 2000)) - 1000));
            f.goal_lon = f.here_lon;
        end else if (sel == 6) begin
            // raw bit patterns, out-of-range values included
            f.here_lat = 31'($urandom);
            f.here_lon = $urandom;
            f.goal_lat = 31'($urandom);
            f.goal_lon = $urandom;
        end else begin
            f.goal_lat = 31'($signed($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX);
            f.goal_lon = int'($urandom_range(0, 32'hB3FF_FFFF)) - LON_MAX;
        end
        return f;
    endfunction

    function automatic fix_t mk_fix(input int hla, input int hlo, input int gla, input int glo);
        fix_t f;
        f.here_lat = 31'(hla);
        f.here_lon = hlo;
        f.goal_lat = 31'(gla);
        f.goal_lon = glo;
        return f;
    endfunction

    task automatic load_directed();
        fix_q.push_back(mk_fix(0, 0, 0, 0));
        fix_q.push_back(mk_fix(LAT_MAX, LON_MAX, LAT_MAX, LON_MAX));
        fix_q.push_back(mk_fix(0, 0, 8388608, 0));
        fix_q.push_back(mk_fix(0, 0, -8388608, 0));
        fix_q.push_back(mk_fix(0, 0, 0, 8388608));
        fix_q.push_back(mk_fix(0, 0, 0, -8388608));
        fix_q.push_back(mk_fix(LAT_MAX, 0, LAT_MAX, 100));
        fix_q.push_back(mk_fix(-LAT_MAX, 0, 0, 0));
        fix_q.push_back(mk_fix(LAT_MAX, 5, -LAT_MAX, -5));
        fix_q.push_back(mk_fix(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX));
        fix_q.push_back(mk_fix(LAT_MAX, LON_MAX, -LAT_MAX, -LON_MAX));
        fix_q.push_back(mk_fix(0, -LON_MAX, 0, LON_MAX));
        fix_q.push_back(mk_fix(0, 0, 1, 1));
        fix_q.push_back(mk_fix(0, 0, -1, -1));
        fix_q.push_back(mk_fix(31'h3FFF_FFFF, 32'h7FFF_FFFF, 31'h4000_0000, 32'h8000_0000));
        fix_q.push_back(mk_fix(31'h4000_0000, 32'h8000_0000, 31'h3FFF_FFFF, 32'h7FFF_FFFF));
        fix_q.push_back(mk_fix(400000000, 300000000, 400000000, -300000000));
        fix_q.push_back(mk_fix(-400000000, 100, 300000000, 100));
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            src_gap <= 0;
        end else begin
            if (s_valid && s_ready) void'(fix_q.pop_front());
            if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                if (s_valid && s_ready) s_valid <= 1'b0;
            end else if ((!s_valid || s_ready) && src_idle_on && $urandom_range(0, 9) == 0) begin
                src_gap <= $urandom_range(1, 13);
                s_valid <= 1'b0;
            end else if ((!s_valid || s_ready) && fix_q.size() > 0) begin
                s_valid <= 1'b1;
                s_here_lat <= fix_q[0].here_lat;
                s_here_lon <= fix_q[0].here_lon;
                s_goal_lat <= fix_q[0].goal_lat;
                s_goal_lon <= fix_q[0].goal_lon;
            end else if (s_valid && s_ready) begin
                s_valid <= 1'b0;
            end
        end
    end

    // queue the expectation at acceptance
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            bearing_q.push_back(predict_bearing(
                {s_here_lat, s_here_lon, s_goal_lat, s_goal_lon}, method_bit));
        end
    end

    // long receiver hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            sink_hold <= 0;
        end else if (hold_req) begin
            sink_hold <= HOLD_CYCLES;
        end else if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
        end
    end

    // monitor
    always @(posedge aclk) begin
        bearing_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            sink_gap <= 0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (m_coincident) coinc_seen++;
                if (method_bit == METHOD_FLAT) flat_seen++;
                else sphere_seen++;
                if (bearing_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected item: heading %0d", m_heading);
                end else begin
                    want = bearing_q.pop_front();
                    if (want.heading !== m_heading || want.coincident !== m_coincident) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: heading exp %0d got %0d, coincident exp %0b got %0b",
                                     want.heading, m_heading, want.coincident, m_coincident);
                    end
                end
            end
            if (hold_req || sink_hold > 0) begin
                m_ready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap <= sink_gap - 1;
                m_ready <= 1'b0;
            end else if (sink_idle_on && $urandom_range(0, 9) == 0) begin
                sink_gap <= $urandom_range(1, 13);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || sink_hold > 0
                || (fix_q.size() == 0 && bearing_q.size() == 0)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG) timed_out <= 1'b1;
        end
    end

    task automatic drain();
        while (fix_q.size() > 0 || s_valid || bearing_q.size() > 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
    endtask

    task automatic set_method(input logic meth);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= meth;
        method_bit <= meth;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_phase(input logic meth, input int n, input bit idle);
        set_method(meth);
        src_idle_on = idle;
        sink_idle_on = idle;
        for (int i = 0; i < n; i++) fix_q.push_back(random_fix());
        drain();
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 1'b0;
        s_valid = 1'b0;
        s_here_lat = '0;
        s_here_lon = '0;
        s_goal_lat = '0;
        s_goal_lon = '0;
        m_ready = 1'b0;
        method_bit = METHOD_SPHERE;
        mismatches = 0;
        results_seen = 0;
        flat_seen = 0;
        sphere_seen = 0;
        coinc_seen = 0;
        src_idle_on = 0;
        sink_idle_on = 0;
        hold_req = 0;
        quiet_cycles = 0;
        timed_out = 0;
        stim_done = 0;
        fill_atan_lut();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed, reset method (spherical) first, then the flat method
        load_directed();
        drain();
        set_method(METHOD_FLAT);
        load_directed();
        drain();

        // long output stall while the input keeps offering items
        hold_req <= 1'b1;
        @(posedge aclk);
        hold_req <= 1'b0;
        for (int i = 0; i < 150; i++) fix_q.push_back(random_fix());
        drain();

        run_phase(METHOD_SPHERE, 250, 1);
        run_phase(METHOD_FLAT, 250, 1);
        run_phase(METHOD_SPHERE, 150, 1);
        run_phase(METHOD_FLAT, 100, 0);
        run_phase(METHOD_SPHERE, 100, 0);
        stim_done = 1'b1;
    end

    initial begin
        wait (aresetn === 1'b1);
        wait (timed_out === 1'b1 || stim_done === 1'b1);
        if (!timed_out) repeat (DRAIN) @(posedge aclk);
        $display("covered %0d results: %0d spherical, %0d flat, %0d coincident",
                 results_seen, sphere_seen, flat_seen, coinc_seen);
        $display("mismatches %0d, leftover expectations %0d", mismatches, bearing_q.size());
        if (timed_out) begin
            $display("[FAIL] regression broken");
        end else if (mismatches == 0 && bearing_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
